// ----- rtl/sti_pkg.sv -----
// Package for the sorted table interpolator: sizes, codes and the cell
// handshake structs. No dependencies.
package sti_pkg;

    localparam int MaxPoints = 64;
    localparam int IdxW      = $clog2(MaxPoints);
    localparam int CntW      = $clog2(MaxPoints + 1);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_LINEAR = 2'd0,
        MODE_LOWER  = 2'd1,
        MODE_UPPER  = 2'd2,
        MODE_RSVD   = 2'd3
    } mode_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FEW  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_DUP  = 2'd3;

    // One point as held in a cell
    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] val;
    } point_t;

    // Command broadcast to every cell for one cycle
    typedef struct packed {
        logic               ins;   // shift-insert at the located position
        logic signed [31:0] key;
        logic signed [31:0] val;
    } cell_cmd_t;

endpackage

// ----- rtl/sti_cell.sv -----
// One storage cell of the point chain: holds a point and takes the left
// neighbour's point when an insert opens a gap to its left. Uses sti_pkg.
module sti_cell (
    input  logic                    aclk,
    input  logic                    valid_i,      // cell lies below point_count
    input  logic                    left_below_i, // left cell valid and key < x
    input  sti_pkg::cell_cmd_t      cmd_i,
    input  sti_pkg::point_t         left_pt_i,
    output sti_pkg::point_t         pt_o,
    output logic                    below_o       // valid and key < x
);
    import sti_pkg::*;

    point_t pt_reg;

    assign pt_o    = pt_reg;
    assign below_o = valid_i && (pt_reg.key < cmd_i.key);

    // Shift right of the insert point, take the new point at it
    always_ff @(posedge aclk) begin
        if (cmd_i.ins) begin
            if (!left_below_i) begin
                if (below_o) begin
                    pt_reg <= pt_reg;
                end else begin
                    pt_reg <= left_pt_i;
                end
            end else if (!below_o) begin
                pt_reg <= '{key: cmd_i.key, val: cmd_i.val};
            end
        end
    end
endmodule

// ----- rtl/sti_div.sv -----
// Serial restoring divider, one quotient bit a cycle, 64-bit dividend by
// 33-bit divisor. No package dependencies.
module sti_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start_i,
    input  logic [63:0] num_i,
    input  logic [32:0] den_i,
    output logic        done_o,
    output logic [63:0] quo_o
);

    logic [63:0] quo_reg, quo_next;
    logic [33:0] rem_reg, rem_next;
    logic [32:0] den_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] trial;

    assign done_o = done_reg;
    assign quo_o  = quo_reg;
    assign trial  = {rem_reg[32:0], quo_reg[63]};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start_i) begin
            quo_next  = num_i;
            rem_next  = '0;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start_i) den_reg <= den_i;
    end
endmodule

// ----- rtl/sorted_table_interpolator.sv -----
// Sorted point table with piecewise linear / step lookup.
// Steps per beat, from accept to next s_ready: clear, no-op and too-few query take accept,
// locate and respond; insert and step query take accept, locate, fetch/shift chain and respond.
// Linear query takes accept, locate, fetch, product, divider start, 64 divider steps, done,
// sum and respond. A result waits in the output register with s_ready low while m_ready is low.
// Sync active-low reset clears count, mode, control.
module sorted_table_interpolator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic signed [31:0] s_x_value,
    input  logic signed [31:0] s_y_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_result_y,
    output logic [1:0]         m_status
);
    import sti_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_LOCATE, S_FETCH, S_MUL, S_START, S_DIV, S_SUM, S_OUT
    } state_t;

    state_t              state_reg;
    mode_t               mode_reg;
    logic [CntW-1:0]     cnt_reg;
    logic [1:0]          op_reg;
    logic signed [31:0]  x_reg, y_reg;
    logic signed [31:0]  res_reg;
    logic [1:0]          st_reg;
    logic [CntW-1:0]     pos_reg;
    logic signed [32:0]  xlo_reg, ylo_reg, xhi_reg, yhi_reg;
    logic [63:0]         prod_reg;
    logic                neg_reg;
    logic                div_start;
    logic                div_done;
    logic [63:0]         div_quo;

    point_t              pts   [MaxPoints];
    logic                below [MaxPoints];
    logic                vld   [MaxPoints];
    cell_cmd_t           cmd;
    logic [CntW-1:0]     pos_sum;

    // Cell chain
    assign cmd = '{ins: (state_reg == S_FETCH) && (op_reg == OP_INSERT)
                       && (st_reg == ST_OK),
                   key: x_reg, val: y_reg};

    for (genvar g = 0; g < MaxPoints; g++) begin : g_cell
        assign vld[g] = (CntW'(g) < cnt_reg);
        if (g == 0) begin : g_first
            sti_cell u_cell (.aclk(aclk), .valid_i(vld[g]), .left_below_i(1'b1),
                .cmd_i(cmd), .left_pt_i(pts[g]), .pt_o(pts[g]), .below_o(below[g]));
        end else begin : g_rest
            sti_cell u_cell (.aclk(aclk), .valid_i(vld[g]),
                .left_below_i(below[g-1]), .cmd_i(cmd), .left_pt_i(pts[g-1]),
                .pt_o(pts[g]), .below_o(below[g]));
        end
    end

    // Keys are sorted, so the below flags form a prefix: encode its end
    always_comb begin
        pos_sum = below[MaxPoints-1] ? CntW'(MaxPoints) : '0;
        for (int i = 1; i < MaxPoints; i++) begin
            if (below[i-1] && !below[i]) pos_sum = pos_sum | CntW'(i);
        end
    end

    sti_div u_div (.aclk(aclk), .aresetn(aresetn), .start_i(div_start),
        .num_i(prod_reg), .den_i(33'(xhi_reg - xlo_reg)), .done_o(div_done),
        .quo_o(div_quo));

    assign div_start = (state_reg == S_START);
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = (state_reg == S_OUT);
    assign m_result_y = res_reg;
    assign m_status   = st_reg;

    logic [IdxW-1:0] lo_idx, hi_idx;
    logic            step_mode;
    logic signed [33:0] dx, dy;
    logic [33:0]     adx, ady;
    logic signed [65:0] sum;

    always_comb begin
        step_mode = (mode_reg == MODE_LOWER) || (mode_reg == MODE_UPPER);
        // clamp position into [1, n-1] then choose the pair
        if (pos_reg == '0) begin
            hi_idx = IdxW'(1);
        end else if (pos_reg >= cnt_reg) begin
            hi_idx = IdxW'(cnt_reg - CntW'(1));
        end else begin
            hi_idx = IdxW'(pos_reg);
        end
        lo_idx = hi_idx - IdxW'(1);
        dx  = 34'(x_reg) - 34'(xlo_reg);
        dy  = 34'(yhi_reg) - 34'(ylo_reg);
        adx = dx[33] ? 34'(-dx) : 34'(dx);
        ady = dy[33] ? 34'(-dy) : 34'(dy);
        sum = neg_reg ? 66'(ylo_reg) - 66'(div_quo) : 66'(ylo_reg) + 66'(div_quo);
    end

    // Control and datapath sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mode_reg  <= MODE_LINEAR;
            cnt_reg   <= '0;
        end else begin
            if (cfg_we) mode_reg <= mode_t'(cfg_wdata);
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg    <= s_operation;
                        x_reg     <= s_x_value;
                        y_reg     <= s_y_value;
                        state_reg <= S_LOCATE;
                    end
                end
                S_LOCATE: begin
                    pos_reg <= pos_sum;
                    res_reg <= '0;
                    case (op_reg)
                        OP_CLEAR: begin
                            cnt_reg   <= '0;
                            st_reg    <= ST_OK;
                            state_reg <= S_OUT;
                        end
                        OP_INSERT: begin
                            state_reg <= S_FETCH;
                            if (cnt_reg >= CntW'(MaxPoints)) begin
                                st_reg <= ST_FULL;
                            end else if (pos_sum < cnt_reg &&
                                         pts[IdxW'(pos_sum)].key == x_reg) begin
                                st_reg <= ST_DUP;
                            end else begin
                                st_reg <= ST_OK;
                            end
                        end
                        OP_QUERY: begin
                            if (step_mode ? (cnt_reg < CntW'(1))
                                          : (cnt_reg < CntW'(2))) begin
                                st_reg    <= ST_FEW;
                                state_reg <= S_OUT;
                            end else begin
                                st_reg    <= ST_OK;
                                state_reg <= S_FETCH;
                            end
                        end
                        default: begin
                            st_reg    <= ST_OK;
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_FETCH: begin
                    if (op_reg == OP_INSERT) begin
                        if (st_reg == ST_OK) cnt_reg <= cnt_reg + CntW'(1);
                        state_reg <= S_OUT;
                    end else if (step_mode) begin
                        if (x_reg <= pts[0].key) begin
                            res_reg <= pts[0].val;
                        end else if (x_reg >= pts[IdxW'(cnt_reg - CntW'(1))].key) begin
                            res_reg <= pts[IdxW'(cnt_reg - CntW'(1))].val;
                        end else if (mode_reg == MODE_LOWER) begin
                            res_reg <= pts[lo_idx].val;
                        end else begin
                            res_reg <= pts[hi_idx].val;
                        end
                        state_reg <= S_OUT;
                    end else begin
                        xlo_reg <= 33'(pts[lo_idx].key);
                        ylo_reg <= 33'(pts[lo_idx].val);
                        xhi_reg <= 33'(pts[hi_idx].key);
                        yhi_reg <= 33'(pts[hi_idx].val);
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    // 32x32 magnitudes fit 64 bits
                    prod_reg  <= adx[31:0] * ady[31:0];
                    neg_reg   <= dx[33] != dy[33];
                    state_reg <= S_START;
                end
                S_START: begin
                    // divider loads the registered product here
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) state_reg <= S_SUM;
                end
                S_SUM: begin
                    if (div_quo > 64'h2_0000_0000) begin
                        res_reg <= neg_reg ? 32'sh8000_0000 : 32'sh7fff_ffff;
                    end else if (sum > 66'sh7fff_ffff) begin
                        res_reg <= 32'sh7fff_ffff;
                    end else if (sum < -66'sh8000_0000) begin
                        res_reg <= 32'sh8000_0000;
                    end else begin
                        res_reg <= sum[31:0];
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/sti_checker.sv -----
// Port-level checker for sorted_table_interpolator, bound to the top level.
// Uses sti_pkg operation and status codes.
module sti_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_operation,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_result_y,
    input logic [1:0]  m_status
);
    import sti_pkg::*;

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_y))
        else $error("result dropped");

    a_clear_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation == OP_CLEAR |=> ##1 m_valid
        && m_status == ST_OK && m_result_y == '0) else $error("clear result");

    a_few_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FEW |-> m_result_y == '0)
        else $error("nonzero value with too few points");
endmodule

bind sorted_table_interpolator sti_checker u_sti_checker (.*);
